FILE: rtl/stuffed_frame_receiver_macros.svh
// Assertion helpers shared by the receiver RTL.
`ifndef STUFFED_FRAME_RECEIVER_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SFR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("stuffed_frame_receiver: check failed");

// Consequent must hold on the clock edge after the antecedent.
`define SFR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stuffed_frame_receiver: sequence check failed");

`endif

FILE: rtl/sfr_pkg.sv
`default_nettype none
package sfr_pkg;

  localparam int BUFFER_BYTES    = 64;
  localparam int ADDR_W          = $clog2(BUFFER_BYTES);
  localparam int CNT_W           = $clog2(BUFFER_BYTES + 1);
  localparam int HEADER_BYTES    = 4;
  localparam int MIN_FRAME_BYTES = 5;
  localparam int GOOD_CNT_W      = 16;

  // Result status codes.
  localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_BAD_SUM = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_ID   = 2'd0;
  localparam logic [1:0] CFG_HEAD_FIRST  = 2'd1;
  localparam logic [1:0] CFG_HEAD_SECOND = 2'd2;

  // Register reset values.
  localparam logic [7:0] DEVICE_ID_RST   = 8'h01;
  localparam logic [7:0] HEAD_FIRST_RST  = 8'hF5;
  localparam logic [7:0] HEAD_SECOND_RST = 8'hAA;

endpackage
`default_nettype wire

FILE: rtl/sfr_ifs.sv
`default_nettype none
// Received byte channel.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface sfr_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [7:0]                     payload_byte;
  logic                           last;
  logic [sfr_pkg::GOOD_CNT_W-1:0] good_frames;

  modport source (output valid, output status, output payload_byte, output last,
                  output good_frames, input ready);
  modport sink   (input valid, input status, input payload_byte, input last,
                  input good_frames, output ready);
endinterface
`default_nettype wire

FILE: rtl/stuffed_frame_receiver.sv
// Channel   | Direction | Contents
// rx_i      | in        | rx_byte: one byte received from the serial link
// res_o     | out       | status, payload_byte, last, good_frames
// cfg_*     | in        | write port for device_id, head_first, head_second
//
// Hunting and payload bytes are taken in S_IDLE; after the length byte that opens
// a frame, S_HDR lets one adder fold the three remaining header bytes into the
// checksum while no byte is taken. The checksum byte leads to S_CHECK; a good frame
// then passes each buffered payload byte through S_RD (memory read) and S_EVAL
// (destuff), then S_FIN for the final result; a full output register stalls these.
// Reset is asynchronous and active low; the frame store is not reset.
// A stalled result holds in the output register while the sequencer waits on it.
`default_nettype none
`include "stuffed_frame_receiver_macros.svh"
module stuffed_frame_receiver (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  sfr_in_if.sink          rx_i,
  sfr_out_if.source       res_o
);

  localparam int AW = sfr_pkg::ADDR_W;
  localparam int CW = sfr_pkg::CNT_W;
  localparam int GW = sfr_pkg::GOOD_CNT_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a byte
  localparam logic [2:0] S_HDR   = 3'd1;  // folding header bytes into the checksum
  localparam logic [2:0] S_CHECK = 3'd2;  // comparing the checksum
  localparam logic [2:0] S_RD    = 3'd3;  // reading a payload byte from the store
  localparam logic [2:0] S_EVAL  = 3'd4;  // destuffing and emitting
  localparam logic [2:0] S_FIN   = 3'd5;  // emitting the final result

  logic [2:0]    state_q, state_d;
  logic [7:0]    dev_id_q, head1_q, head2_q;
  logic [7:0]    hist_q [3];
  logic [7:0]    hist_d [3];
  logic          collect_q, collect_d;
  logic [CW-1:0] wi_q, wi_d;
  logic [CW-1:0] len_q, len_d;
  logic [7:0]    hdr_q [3];
  logic [7:0]    hdr_d [3];
  logic [1:0]    hcnt_q, hcnt_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    chk_q, chk_d;
  logic [GW-1:0] good_cnt_q, good_cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [7:0]    rd_q;
  logic [7:0]    p1_q, p1_d, p2_q, p2_d;
  logic [7:0]    pend_q, pend_d;
  logic          pend_v_q, pend_v_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic [GW-1:0] out_cnt_q, out_cnt_d;

  logic [7:0]    mem [sfr_pkg::BUFFER_BYTES];
  logic          mem_we;

  logic          in_fire, out_free, out_load;
  logic [7:0]    rx_b;
  logic          hdr_match, len_ok, drop, need_emit;
  logic [7:0]    add_op;
  logic          add_en;

  assign rx_i.ready = (state_q == S_IDLE);
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign rx_b       = rx_i.rx_byte;
  assign out_free   = !out_valid_q || res_o.ready;

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_status_q;
  assign res_o.payload_byte = out_byte_q;
  assign res_o.last         = out_last_q;
  assign res_o.good_frames  = out_cnt_q;

  // A frame opens on head_first, head_second, device_id followed by a nonzero length.
  assign hdr_match = (rx_b != 8'd0) && (hist_q[0] == dev_id_q) &&
                     (hist_q[1] == head2_q) && (hist_q[2] == head1_q);
  assign len_ok    = (rx_b >= 8'(sfr_pkg::MIN_FRAME_BYTES)) &&
                     (rx_b <= 8'(sfr_pkg::BUFFER_BYTES));

  // A zero right after the header pair is a stuffing byte and is dropped.
  assign drop      = (rd_q == 8'd0) && (p1_q == head2_q) && (p2_q == head1_q);
  assign need_emit = !drop && pend_v_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q <= sfr_pkg::DEVICE_ID_RST;
      head1_q  <= sfr_pkg::HEAD_FIRST_RST;
      head2_q  <= sfr_pkg::HEAD_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfr_pkg::CFG_DEVICE_ID:   dev_id_q <= cfg_data_i;
        sfr_pkg::CFG_HEAD_FIRST:  head1_q  <= cfg_data_i;
        sfr_pkg::CFG_HEAD_SECOND: head2_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame store: payload and checksum bytes, one write and one registered read.
  assign mem_we = in_fire && collect_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wi_q[AW-1:0]] <= rx_b;
    end
    rd_q <= mem[idx_q[AW-1:0]];
  end

  // The one checksum adder, shared between header folding and payload bytes.
  assign sum_d = add_en ? 8'(sum_q + add_op) :
                 (in_fire && !collect_q && hdr_match && len_ok) ? head1_q : sum_q;

  always_comb begin
    state_d      = state_q;
    hist_d       = hist_q;
    collect_d    = collect_q;
    wi_d         = wi_q;
    len_d        = len_q;
    hdr_d        = hdr_q;
    hcnt_d       = hcnt_q;
    chk_d        = chk_q;
    good_cnt_d   = good_cnt_q;
    idx_d        = idx_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    pend_d       = pend_q;
    pend_v_d     = pend_v_q;
    add_op       = rx_b;
    add_en       = 1'b0;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_cnt_d    = out_cnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!collect_q) begin
            if (hdr_match) begin
              hist_d = '{8'd0, 8'd0, 8'd0};
              if (len_ok) begin
                collect_d = 1'b1;
                wi_d      = CW'(sfr_pkg::HEADER_BYTES);
                len_d     = CW'(rx_b);
                hdr_d     = '{head2_q, dev_id_q, rx_b};
                hcnt_d    = 2'd0;
                state_d   = S_HDR;
              end
            end else begin
              hist_d = '{rx_b, hist_q[0], hist_q[1]};
            end
          end else if ((wi_q + CW'(1)) >= len_q) begin
            // Checksum byte: the frame is complete.
            chk_d     = rx_b;
            collect_d = 1'b0;
            wi_d      = '0;
            state_d   = S_CHECK;
          end else begin
            add_en = 1'b1;
            wi_d   = wi_q + CW'(1);
          end
        end
      end

      S_HDR: begin
        add_op = hdr_q[hcnt_q];
        add_en = 1'b1;
        hcnt_d = hcnt_q + 2'd1;
        if (hcnt_q == 2'd2) begin
          state_d = S_IDLE;
        end
      end

      S_CHECK: begin
        if (sum_q != chk_q) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_status_d = sfr_pkg::STATUS_BAD_SUM;
            out_byte_d   = 8'd0;
            out_last_d   = 1'b1;
            out_cnt_d    = good_cnt_q;
            state_d      = S_IDLE;
          end
        end else begin
          good_cnt_d = good_cnt_q + GW'(1);
          idx_d      = CW'(sfr_pkg::HEADER_BYTES);
          p1_d       = 8'd0;
          p2_d       = 8'd0;
          pend_v_d   = 1'b0;
          state_d    = (len_q == CW'(sfr_pkg::HEADER_BYTES + 1)) ? S_FIN : S_RD;
        end
      end

      S_RD: begin
        state_d = S_EVAL;
      end

      S_EVAL: begin
        // One result is held back so the final one can carry last.
        if (!need_emit || out_free) begin
          if (need_emit) begin
            out_load     = 1'b1;
            out_status_d = sfr_pkg::STATUS_PAYLOAD;
            out_byte_d   = pend_q;
            out_last_d   = 1'b0;
            out_cnt_d    = good_cnt_q;
          end
          if (!drop) begin
            pend_d   = rd_q;
            pend_v_d = 1'b1;
          end
          p2_d  = p1_q;
          p1_d  = rd_q;
          idx_d = idx_q + CW'(1);
          if (({1'b0, idx_q} + (CW + 1)'(2)) >= {1'b0, len_q}) begin
            state_d = S_FIN;
          end else begin
            state_d = S_RD;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = pend_v_q ? sfr_pkg::STATUS_PAYLOAD : sfr_pkg::STATUS_EMPTY;
          out_byte_d   = pend_v_q ? pend_q : 8'd0;
          out_last_d   = 1'b1;
          out_cnt_d    = good_cnt_q;
          pend_v_d     = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hist_q      <= '{8'd0, 8'd0, 8'd0};
      collect_q   <= 1'b0;
      wi_q        <= '0;
      len_q       <= '0;
      hcnt_q      <= 2'd0;
      good_cnt_q  <= '0;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hist_q      <= hist_d;
      collect_q   <= collect_d;
      wi_q        <= wi_d;
      len_q       <= len_d;
      hcnt_q      <= hcnt_d;
      good_cnt_q  <= good_cnt_d;
      idx_q       <= idx_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    hdr_q        <= hdr_d;
    sum_q        <= sum_d;
    chk_q        <= chk_d;
    p1_q         <= p1_d;
    p2_q         <= p2_d;
    pend_q       <= pend_d;
    out_status_q <= out_status_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_cnt_q    <= out_cnt_d;
  end

  // While collecting, the write index stays inside the frame past the header.
  `SFR_ASSERT(a_wi_range, clk_i, rst_ni, !collect_q || ((wi_q < len_q) && (wi_q >= CW'(sfr_pkg::HEADER_BYTES))))
  // A matching checksum bumps the good-frame count by exactly one.
  `SFR_ASSERT_NEXT(a_good_inc, clk_i, rst_ni, (state_q == S_CHECK) && (sum_q == chk_q), good_cnt_q == $past(good_cnt_q) + GW'(1))
  // A checksum error is always the final result of its frame.
  `SFR_ASSERT(a_err_last, clk_i, rst_ni, !(out_valid_q && (out_status_q == sfr_pkg::STATUS_BAD_SUM)) || out_last_q)
  // The drain never reads the checksum byte or beyond.
  `SFR_ASSERT(a_drain_range, clk_i, rst_ni, (state_q != S_EVAL) || (({1'b0, idx_q} + (CW + 1)'(1)) < {1'b0, len_q}))

endmodule
`default_nettype wire
